// ----- rtl/grid_neighbor_index_macros.svh -----
// Assertion macros for the grid neighbor index block.
// Used by the top level only; expects a clock named clk and a reset named rst.
`ifndef GRID_NEIGHBOR_INDEX_MACROS_SVH
`define GRID_NEIGHBOR_INDEX_MACROS_SVH

// Same-cycle implication, masked during reset
`define GNI_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked during reset
`define GNI_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset
`define GNI_CHECK_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/gni_pkg.sv -----
// Shared types and constants for the grid neighbor index block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package gni_pkg;

  localparam int IDX_W     = 20;  // linear pixel index width
  localparam int CODE_W    = 4;   // direction code width
  localparam int CFG_W     = 11;  // widest configuration register
  localparam int CFG_IDX_W = 1;   // configuration register index width

  // Direction codes; "bottom" is row - 1, "top" is row + 1
  typedef enum logic [CODE_W-1:0] {
    DIR_SELF         = 4'd0,
    DIR_LEFT         = 4'd1,
    DIR_RIGHT        = 4'd2,
    DIR_BOTTOM_LEFT  = 4'd3,
    DIR_BOTTOM       = 4'd4,
    DIR_BOTTOM_RIGHT = 4'd5,
    DIR_TOP_LEFT     = 4'd6,
    DIR_TOP          = 4'd7,
    DIR_TOP_RIGHT    = 4'd8
  } dir_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] GRID_SIDE_RESET = 11'd1024;

  // Transaction payload carried down the divider chain
  typedef struct packed {
    logic [IDX_W-1:0]  pix;   // centre pixel index
    logic [CODE_W-1:0] code;  // direction code
    logic [IDX_W-1:0]  quot;  // row, built one bit per cell
  } item_t;

endpackage

// ----- rtl/gni_div_cell.sv -----
// One restoring-division cell: resolves one quotient (row) bit per transaction.
// Depends on gni_pkg for item_t.
`timescale 1ns / 1ps

module gni_div_cell
  import gni_pkg::*;
#(
  parameter int SW  = 11,  // width of the clamped grid side
  parameter int BIT = 0    // quotient bit resolved here
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [SW-1:0] w,
  input  logic          up_valid,
  output logic          up_ready,
  input  item_t         up_item,
  input  logic [SW-1:0] up_rem,
  output logic          dn_valid,
  input  logic          dn_ready,
  output item_t         dn_item,
  output logic [SW-1:0] dn_rem
);

  logic [SW:0]   trial;
  logic          ge;
  logic [SW:0]   diff;
  logic [SW-1:0] rem_next;
  item_t         item_next;

  // Shift in the next dividend bit and try to subtract the width
  always_comb begin
    trial     = {up_rem, up_item.pix[BIT]};
    ge        = (trial >= {1'b0, w});
    diff      = trial - {1'b0, w};
    rem_next  = ge ? diff[SW-1:0] : trial[SW-1:0];
    item_next = up_item;
    item_next.quot[BIT] = ge;
  end

  // Stage takes a new transaction when empty or when it hands its own on
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_item <= item_next;
      dn_rem  <= rem_next;
    end
  end

endmodule

// ----- rtl/gni_out_stage.sv -----
// Output stage: edge checks and neighbor index from column, row and direction.
// Depends on gni_pkg for item_t and direction codes.
`timescale 1ns / 1ps

module gni_out_stage
  import gni_pkg::*;
#(
  parameter int SW = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [SW-1:0]    w,
  input  logic [SW-1:0]    h,
  input  logic             up_valid,
  output logic             up_ready,
  input  item_t            up_item,
  input  logic [SW-1:0]    up_rem,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] neighbor_index,
  output logic             in_grid
);

  logic             dx_neg, dx_pos, dy_neg, dy_pos, known;
  logic             ok;
  logic [SW:0]      col_inc;
  logic [IDX_W:0]   row_inc;
  logic [IDX_W-1:0] w_ext;
  logic [IDX_W-1:0] idx_next;
  logic             grid_next;

  // Direction decode
  always_comb begin
    dx_neg = 1'b0;
    dx_pos = 1'b0;
    dy_neg = 1'b0;
    dy_pos = 1'b0;
    known  = 1'b1;
    case (dir_t'(up_item.code))
      DIR_SELF:         begin end
      DIR_LEFT:         dx_neg = 1'b1;
      DIR_RIGHT:        dx_pos = 1'b1;
      DIR_BOTTOM_LEFT:  begin dx_neg = 1'b1; dy_neg = 1'b1; end
      DIR_BOTTOM:       dy_neg = 1'b1;
      DIR_BOTTOM_RIGHT: begin dx_pos = 1'b1; dy_neg = 1'b1; end
      DIR_TOP_LEFT:     begin dx_neg = 1'b1; dy_pos = 1'b1; end
      DIR_TOP:          dy_pos = 1'b1;
      DIR_TOP_RIGHT:    begin dx_pos = 1'b1; dy_pos = 1'b1; end
      default:          known = 1'b0;
    endcase
  end

  // Edge checks; col is the remainder, row the quotient
  always_comb begin
    col_inc = {1'b0, up_rem} + 1'b1;
    row_inc = {1'b0, up_item.quot} + 1'b1;
    w_ext   = IDX_W'(w);
    ok = known
      && (up_item.quot < IDX_W'(h))
      && !(dx_neg && (up_rem == '0))
      && !(dx_pos && (col_inc >= {1'b0, w}))
      && !(dy_neg && (up_item.quot == '0))
      && !(dy_pos && (row_inc >= (IDX_W + 1)'(h)));

    // pix = row * w + col, so the neighbor is pix +/- 1 +/- w
    idx_next = up_item.pix;
    if (dx_pos) idx_next = idx_next + 1'b1;
    if (dx_neg) idx_next = idx_next - 1'b1;
    if (dy_pos) idx_next = idx_next + w_ext;
    if (dy_neg) idx_next = idx_next - w_ext;

    if (dir_t'(up_item.code) == DIR_SELF) begin
      idx_next  = up_item.pix;
      grid_next = 1'b1;
    end else if (ok) begin
      grid_next = 1'b1;
    end else begin
      idx_next  = '0;
      grid_next = 1'b0;
    end
  end

  assign up_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      neighbor_index <= idx_next;
      in_grid        <= grid_next;
    end
  end

endmodule

// ----- rtl/grid_neighbor_index.sv -----
// Top level of the grid neighbor index block: config registers, divider chain,
// output stage. Depends on gni_pkg, gni_div_cell, gni_out_stage and the macro header.
//
//  channel   direction  handshake                fields
//  in        in         in_valid / in_ready      pixel_index, neighbor_code
//  out       out        out_valid / out_ready    neighbor_index, in_grid
//  cfg       in         cfg_we (no wait)         cfg_index, cfg_data
//
// One transaction per cycle unless the output stalls; one cell per row bit of the
// 20-bit index (a restoring divider by the grid width), then the output register.
// Reset clears all valid bits and sets width and height to 1024.
// Each stage holds its transaction while the next one is full, so a stall at the
// output fills the chain from the back and in_ready falls only when it is full.
`timescale 1ns / 1ps
`include "grid_neighbor_index_macros.svh"

module grid_neighbor_index
  import gni_pkg::*;
#(
  parameter int MAX_SIDE = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IDX_W-1:0]     pixel_index,
  input  logic [CODE_W-1:0]    neighbor_code,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_W-1:0]     neighbor_index,
  output logic                 in_grid
);

  localparam int SW = $clog2(MAX_SIDE + 1);

  logic [CFG_W-1:0] grid_width;
  logic [CFG_W-1:0] grid_height;
  logic [SW-1:0]    w_eff;
  logic [SW-1:0]    h_eff;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_SIDE_RESET;
      grid_height <= GRID_SIDE_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: begin end
      endcase
    end
  end

  // Zero reads as one, anything above MAX_SIDE saturates
  always_comb begin
    if (grid_width == '0)                          w_eff = SW'(1);
    else if (32'(grid_width) > 32'(MAX_SIDE))      w_eff = SW'(MAX_SIDE);
    else                                           w_eff = SW'(grid_width);
    if (grid_height == '0)                         h_eff = SW'(1);
    else if (32'(grid_height) > 32'(MAX_SIDE))     h_eff = SW'(MAX_SIDE);
    else                                           h_eff = SW'(grid_height);
  end

  // Divider chain, most significant row bit first
  logic          valid_chain [IDX_W+1];
  logic          ready_chain [IDX_W+1];
  item_t         item_chain  [IDX_W+1];
  logic [SW-1:0] rem_chain   [IDX_W+1];

  assign valid_chain[0]     = in_valid;
  assign in_ready           = ready_chain[0];
  assign item_chain[0].pix  = pixel_index;
  assign item_chain[0].code = neighbor_code;
  assign item_chain[0].quot = '0;
  assign rem_chain[0]       = '0;

  for (genvar i = 0; i < IDX_W; i++) begin : g_cell
    gni_div_cell #(
      .SW  (SW),
      .BIT (IDX_W - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .w        (w_eff),
      .up_valid (valid_chain[i]),
      .up_ready (ready_chain[i]),
      .up_item  (item_chain[i]),
      .up_rem   (rem_chain[i]),
      .dn_valid (valid_chain[i+1]),
      .dn_ready (ready_chain[i+1]),
      .dn_item  (item_chain[i+1]),
      .dn_rem   (rem_chain[i+1])
    );
  end

  gni_out_stage #(
    .SW (SW)
  ) u_out (
    .clk            (clk),
    .rst            (rst),
    .w              (w_eff),
    .h              (h_eff),
    .up_valid       (valid_chain[IDX_W]),
    .up_ready       (ready_chain[IDX_W]),
    .up_item        (item_chain[IDX_W]),
    .up_rem         (rem_chain[IDX_W]),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .neighbor_index (neighbor_index),
    .in_grid        (in_grid)
  );

  // Checks
  `GNI_CHECK(a_col_below_width, valid_chain[IDX_W], rem_chain[IDX_W] < w_eff, "column not below width")
  `GNI_CHECK(a_absent_is_zero, out_valid && !in_grid, neighbor_index == '0, "absent neighbor nonzero")
  `GNI_CHECK_ALWAYS(a_reset_empties, rst, !out_valid && !valid_chain[IDX_W], "valid after reset")

endmodule
